FILE: hdl/tcpm_pkg.sv
`default_nettype none
package tcpm_pkg;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic               clutch_engaged;
    } t_in;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] target_qw;
        logic signed [31:0] target_qx;
        logic signed [31:0] target_qy;
        logic signed [31:0] target_qz;
        logic               holding;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWICE,
        ST_ROOT,
        ST_DIV,
        ST_POS,
        ST_QMUL,
        ST_OUT
    } t_state;

    typedef enum logic {
        RD_DIV,
        RD_SQRT
    } t_rdiv_mode;

    typedef struct packed {
        logic       start;
        t_rdiv_mode mode;
    } t_rdiv_ctl;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_rdiv_sts;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEED = 1'b1;

    localparam logic [3:0]         SCALE_RESET = 4'd3;
    localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [39:0] TRACE_INIT  = 40'sd2147483648;
    localparam logic signed [39:0] TRACE_MAX   = 40'sd17179869183;

    // Weights of each doubled product into (trace, n1, n2, n3).
    // Product order: wy, xx, zz, yz, wx, xy, wz, yy.
    localparam logic signed [2:0] TW_COEF [8][4] = '{
        '{ 3'sd2,  3'sd0,  3'sd0,  3'sd0},
        '{-3'sd1,  3'sd0,  3'sd1,  3'sd0},
        '{-3'sd1,  3'sd0,  3'sd1,  3'sd0},
        '{ 3'sd0,  3'sd1,  3'sd0,  3'sd1},
        '{ 3'sd0,  3'sd1,  3'sd0, -3'sd1},
        '{ 3'sd0,  3'sd1,  3'sd0, -3'sd1},
        '{ 3'sd0,  3'sd1,  3'sd0,  3'sd1},
        '{ 3'sd0,  3'sd0,  3'sd2,  3'sd0}
    };

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 64'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] negsat(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == S32_MIN) begin
            r = S32_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic signed [39:0] coef_term(input logic signed [39:0] v,
                                                     input logic signed [2:0] c);
        logic signed [39:0] r;
        case (c)
            3'sd1:   r = v;
            -3'sd1:  r = -v;
            3'sd2:   r = v <<< 1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/teleop_clutch_pose_mapper_unit.sv
// Clutch pose mapper for one arm of a master-slave teleoperation setup.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): one request per
// control tick (opcode tick: haptic position, orientation, clutch button) or a
// seed request (end-effector position that loads the hold pose once).
// Output channel (o_out_valid / i_out_stall, payload o_out_data): one result
// per tick request, none per seed. Config channel (i_cfg_valid / o_cfg_ready,
// i_cfg_data) writes motion_scale; it is ready only while the block is idle.
// A seed request is applied on acceptance and leaves the block idle. A tick
// request runs 27 products on one bit-serial 32x32 multiplier, a square root
// and three divides on a shared bit-serial root/divide unit; the divides are
// skipped when the orientation trace is zero. One request is in work at a
// time; o_in_stall is low again once the result enters the output register,
// even if the receiver has not yet taken it.
// If the receiver stalls, the result waits in the output register; a second
// finished result waits in the sequencer until the register drains.
// Reset (synchronous, active low) sets motion_scale to 3, all stored
// quaternions to identity, positions and offsets to zero, and clears the hold
// and seed flags.
`default_nettype none
module teleop_clutch_pose_mapper_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  tcpm_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output tcpm_pkg::t_out     o_out_data,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire         [3:0]  i_cfg_data
);
    import tcpm_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [3:0]         r_idx;
    logic               r_go;
    logic [3:0]         r_scale;
    logic               r_engaged;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_lhq [4];      // last haptic quaternion, w x y z
    logic signed [31:0] r_lcp [3];      // last commanded position
    logic signed [31:0] r_lcq [4];      // last commanded quaternion
    logic signed [31:0] r_hold_pos [3];
    logic signed [31:0] r_hold_quat [4];
    logic signed [31:0] r_off_pos [3];
    logic signed [31:0] r_off_quat [4];
    logic               r_hold_latched;
    logic               r_seed_taken;
    logic signed [39:0] r_acc [4];      // trace, n1, n2, n3
    logic signed [31:0] r_e [4];        // robot-frame orientation
    logic signed [63:0] r_qacc;
    t_out               r_out;
    logic               r_out_vld;

    logic               in_acc;
    logic               tick_acc;
    logic               cfg_acc;
    logic               out_free;
    logic               out_load;
    logic               step_done;
    logic               step_last;
    logic               ew_zero;
    logic               mul_start;
    logic               mul_done;
    logic signed [63:0] mul_prod;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic               qm_neg;
    t_rdiv_ctl          rd_ctl;
    t_rdiv_sts          rd_sts;
    logic [31:0]        rd_res;
    logic [63:0]        radicand;
    logic [33:0]        trace_c;
    logic signed [39:0] num_s;
    logic [39:0]        num_mag;
    logic [33:0]        den;
    logic signed [31:0] qa [4];
    logic signed [31:0] qb [4];
    logic signed [63:0] tw_full;
    logic signed [39:0] tw;
    logic signed [63:0] pt;
    logic signed [63:0] q_sum;
    logic signed [63:0] q_shift;
    logic signed [31:0] div_val;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign tick_acc = in_acc && (i_in_data.opcode == OP_TICK);
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_vld || !i_out_stall;
    assign ew_zero  = (rd_res[31:1] == 31'd0);

    // Step bookkeeping for the sequencer.
    always_comb begin
        step_done = 1'b0;
        step_last = 1'b0;
        case (r_state)
            ST_TWICE: begin
                step_done = mul_done;
                step_last = (r_idx == 4'd7);
            end
            ST_ROOT: begin
                step_done = rd_sts.done;
                step_last = 1'b1;
            end
            ST_DIV: begin
                step_done = rd_sts.done;
                step_last = (r_idx == 4'd2);
            end
            ST_POS: begin
                step_done = mul_done;
                step_last = (r_idx == 4'd2);
            end
            ST_QMUL: begin
                step_done = mul_done;
                step_last = (r_idx == 4'd15);
            end
            default: begin
                step_done = 1'b0;
                step_last = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (tick_acc) n_state = ST_TWICE;
            ST_TWICE: if (step_done && step_last) n_state = ST_ROOT;
            ST_ROOT:  if (step_done) n_state = ew_zero ? ST_POS : ST_DIV;
            ST_DIV:   if (step_done && step_last) n_state = ST_POS;
            ST_POS:   if (step_done && step_last) n_state = ST_QMUL;
            ST_QMUL:  if (step_done && step_last) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
        mul_start   = r_go && ((r_state == ST_TWICE) || (r_state == ST_POS) ||
                               (r_state == ST_QMUL));
        rd_ctl.start = r_go && ((r_state == ST_ROOT) || (r_state == ST_DIV));
        rd_ctl.mode  = (r_state == ST_ROOT) ? RD_SQRT : RD_DIV;
        out_load    = (r_state == ST_OUT) && out_free;
    end

    // Quaternion product operands: engaged -> offset * e, released -> hold * conj(e).
    always_comb begin
        qb[0] = r_e[0];
        for (int i = 0; i < 4; i++) begin
            qa[i] = r_engaged ? r_off_quat[i] : r_hold_quat[i];
        end
        for (int i = 1; i < 4; i++) begin
            qb[i] = r_engaged ? r_e[i] : negsat(r_e[i]);
        end
    end

    // Multiplier operand schedule.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        qm_neg = 1'b0;
        case (r_state)
            ST_TWICE: begin
                case (r_idx[2:0])
                    3'd0:    begin mul_a = r_lhq[0]; mul_b = r_lhq[2]; end
                    3'd1:    begin mul_a = r_lhq[1]; mul_b = r_lhq[1]; end
                    3'd2:    begin mul_a = r_lhq[3]; mul_b = r_lhq[3]; end
                    3'd3:    begin mul_a = r_lhq[2]; mul_b = r_lhq[3]; end
                    3'd4:    begin mul_a = r_lhq[0]; mul_b = r_lhq[1]; end
                    3'd5:    begin mul_a = r_lhq[1]; mul_b = r_lhq[2]; end
                    3'd6:    begin mul_a = r_lhq[0]; mul_b = r_lhq[3]; end
                    default: begin mul_a = r_lhq[2]; mul_b = r_lhq[2]; end
                endcase
            end
            ST_POS: begin
                mul_b = $signed({28'd0, r_scale});
                case (r_idx[1:0])
                    2'd0:    mul_a = r_pos[0];
                    2'd1:    mul_a = r_pos[1];
                    default: mul_a = r_pos[2];
                endcase
            end
            ST_QMUL: begin
                case (r_idx)
                    4'd0:    begin mul_a = qa[0]; mul_b = qb[0]; end
                    4'd1:    begin mul_a = qa[1]; mul_b = qb[1]; qm_neg = 1'b1; end
                    4'd2:    begin mul_a = qa[2]; mul_b = qb[2]; qm_neg = 1'b1; end
                    4'd3:    begin mul_a = qa[3]; mul_b = qb[3]; qm_neg = 1'b1; end
                    4'd4:    begin mul_a = qa[0]; mul_b = qb[1]; end
                    4'd5:    begin mul_a = qa[1]; mul_b = qb[0]; end
                    4'd6:    begin mul_a = qa[2]; mul_b = qb[3]; end
                    4'd7:    begin mul_a = qa[3]; mul_b = qb[2]; qm_neg = 1'b1; end
                    4'd8:    begin mul_a = qa[0]; mul_b = qb[2]; end
                    4'd9:    begin mul_a = qa[1]; mul_b = qb[3]; qm_neg = 1'b1; end
                    4'd10:   begin mul_a = qa[2]; mul_b = qb[0]; end
                    4'd11:   begin mul_a = qa[3]; mul_b = qb[1]; end
                    4'd12:   begin mul_a = qa[0]; mul_b = qb[3]; end
                    4'd13:   begin mul_a = qa[1]; mul_b = qb[2]; end
                    4'd14:   begin mul_a = qa[2]; mul_b = qb[1]; qm_neg = 1'b1; end
                    default: begin mul_a = qa[3]; mul_b = qb[0]; end
                endcase
            end
            default: begin
                mul_a  = '0;
                mul_b  = '0;
                qm_neg = 1'b0;
            end
        endcase
    end

    // Trace clamp, root radicand, divider operands and result shaping.
    always_comb begin
        if (r_acc[0][39]) begin
            trace_c = '0;
        end else if (r_acc[0] > TRACE_MAX) begin
            trace_c = TRACE_MAX[33:0];
        end else begin
            trace_c = r_acc[0][33:0];
        end
        radicand = {trace_c, 30'd0};
        case (r_idx[1:0])
            2'd0:    num_s = r_acc[1];
            2'd1:    num_s = r_acc[2];
            default: num_s = r_acc[3];
        endcase
        num_mag = num_s[39] ? 40'(-num_s) : 40'(num_s);
        den     = {1'b0, r_e[0][30:0], 2'b00};
        if (rd_sts.ovf) begin
            div_val = num_s[39] ? S32_MIN : S32_MAX;
        end else begin
            div_val = num_s[39] ? -$signed({1'b0, rd_res[30:0]})
                                : $signed({1'b0, rd_res[30:0]});
        end
        tw_full = mul_prod >>> 29;
        tw      = tw_full[39:0];
        pt      = mul_prod >>> 2;
        q_sum   = ((r_idx[1:0] == 2'd0) ? 64'sd0 : r_qacc) + (qm_neg ? -pt : pt);
        q_shift = q_sum >>> 28;
    end

    tcpm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tcpm_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rd_ctl),
        .i_rad   (radicand),
        .i_num   (num_mag),
        .i_den   (den),
        .o_sts   (rd_sts),
        .o_res   (rd_res)
    );

    // Sequencer and pose state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_idx          <= '0;
            r_go           <= 1'b0;
            r_scale        <= SCALE_RESET;
            r_hold_latched <= 1'b0;
            r_seed_taken   <= 1'b0;
            r_out_vld      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_lcp[i]      <= '0;
                r_hold_pos[i] <= '0;
                r_off_pos[i]  <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_lhq[i]       <= (i == 0) ? Q30_ONE : '0;
                r_lcq[i]       <= (i == 0) ? Q30_ONE : '0;
                r_hold_quat[i] <= (i == 0) ? Q30_ONE : '0;
                r_off_quat[i]  <= (i == 0) ? Q30_ONE : '0;
            end
        end else begin
            r_state <= n_state;
            r_go    <= tick_acc || (step_done && !(r_state == ST_QMUL && step_last));

            if (cfg_acc) begin
                r_scale <= i_cfg_data;
            end

            if (tick_acc) begin
                r_idx <= '0;
            end else if (step_done) begin
                r_idx <= step_last ? 4'd0 : r_idx + 4'd1;
            end

            if (in_acc && i_in_data.opcode == OP_SEED && !r_seed_taken) begin
                r_hold_pos[0] <= i_in_data.pos_x;
                r_hold_pos[1] <= i_in_data.pos_y;
                r_hold_pos[2] <= i_in_data.pos_z;
                for (int i = 0; i < 4; i++) begin
                    r_hold_quat[i] <= r_lhq[i];
                end
                r_seed_taken <= 1'b1;
            end

            if (tick_acc) begin
                r_lhq[0] <= i_in_data.quat_w;
                r_lhq[1] <= i_in_data.quat_x;
                r_lhq[2] <= i_in_data.quat_y;
                r_lhq[3] <= i_in_data.quat_z;
                if (i_in_data.clutch_engaged) begin
                    r_hold_latched <= 1'b0;
                end else if (!r_hold_latched) begin
                    // first released tick: freeze the last command as hold pose
                    for (int i = 0; i < 3; i++) begin
                        r_hold_pos[i] <= r_lcp[i];
                    end
                    for (int i = 0; i < 4; i++) begin
                        r_hold_quat[i] <= r_lcq[i];
                    end
                    r_hold_latched <= 1'b1;
                end
            end

            if (mul_done && r_state == ST_POS) begin
                if (r_engaged) begin
                    r_lcp[r_idx[1:0]] <= sat32(mul_prod - 64'(r_off_pos[r_idx[1:0]]));
                end else begin
                    r_off_pos[r_idx[1:0]] <= sat32(mul_prod - 64'(r_hold_pos[r_idx[1:0]]));
                end
            end

            if (mul_done && r_state == ST_QMUL && r_idx[1:0] == 2'd3) begin
                if (r_engaged) begin
                    r_lcq[r_idx[3:2]] <= sat32(q_shift);
                end else begin
                    r_off_quat[r_idx[3:2]] <= sat32(q_shift);
                end
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working registers of one tick.
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_engaged <= i_in_data.clutch_engaged;
            r_pos[0]  <= i_in_data.pos_x;
            r_pos[1]  <= i_in_data.pos_y;
            r_pos[2]  <= i_in_data.pos_z;
            r_acc[0]  <= TRACE_INIT;
            r_acc[1]  <= '0;
            r_acc[2]  <= -TRACE_INIT;
            r_acc[3]  <= '0;
        end
        if (mul_done && r_state == ST_TWICE) begin
            for (int j = 0; j < 4; j++) begin
                r_acc[j] <= r_acc[j] + coef_term(tw, TW_COEF[r_idx[2:0]][j]);
            end
        end
        if (rd_sts.done && r_state == ST_ROOT) begin
            r_e[0] <= $signed({1'b0, rd_res[31:1]});
            if (ew_zero) begin
                r_e[1] <= '0;
                r_e[2] <= '0;
                r_e[3] <= '0;
            end
        end
        if (rd_sts.done && r_state == ST_DIV) begin
            r_e[r_idx[1:0] + 2'd1] <= div_val;
        end
        if (mul_done && r_state == ST_QMUL) begin
            r_qacc <= q_sum;
        end
        if (out_load) begin
            if (r_engaged) begin
                r_out.target_x  <= r_lcp[0];
                r_out.target_y  <= r_lcp[1];
                r_out.target_z  <= r_lcp[2];
                r_out.target_qw <= r_lcq[0];
                r_out.target_qx <= r_lcq[1];
                r_out.target_qy <= r_lcq[2];
                r_out.target_qz <= r_lcq[3];
                r_out.holding   <= 1'b0;
            end else begin
                r_out.target_x  <= r_hold_pos[0];
                r_out.target_y  <= r_hold_pos[1];
                r_out.target_z  <= r_hold_pos[2];
                r_out.target_qw <= r_hold_quat[0];
                r_out.target_qx <= r_hold_quat[1];
                r_out.target_qy <= r_hold_quat[2];
                r_out.target_qz <= r_hold_quat[3];
                r_out.holding   <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_start && rd_ctl.start))
        else $error("multiplier and root/divide unit started together");

    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> (r_state == ST_TWICE) && r_go)
        else $error("accepted tick request did not start the product schedule");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_TWICE || r_state == ST_POS || r_state == ST_QMUL))
        else $error("multiplier finished outside a product step");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_sts.done |-> (r_state == ST_ROOT || r_state == ST_DIV))
        else $error("root/divide unit finished outside its step");
`endif
endmodule
`default_nettype wire

FILE: hdl/tcpm_mul.sv
`default_nettype none
module tcpm_mul (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed  [31:0] i_a,
    input  wire signed  [31:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_prod
);
    // Radix-2 shift-add, one multiplier bit per cycle; sign bit weighs -2^31.
    logic signed [33:0] r_hi;
    logic [31:0]        r_lo;
    logic signed [31:0] r_a;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic signed [33:0] a_ext;
    logic signed [33:0] addend;
    logic signed [33:0] sum;

    always_comb begin
        a_ext  = 34'(r_a);
        addend = '0;
        if (r_lo[0]) begin
            addend = (r_cnt == 5'd31) ? -a_ext : a_ext;
        end
        sum = r_hi + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi <= '0;
            r_lo <= i_b;
            r_a  <= i_a;
        end else if (r_busy) begin
            r_hi <= sum >>> 1;
            r_lo <= {sum[0], r_lo[31:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed({r_hi[31:0], r_lo});
endmodule
`default_nettype wire

FILE: hdl/tcpm_rdiv.sv
`default_nettype none
module tcpm_rdiv (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  tcpm_pkg::t_rdiv_ctl        i_ctl,
    input  wire                 [63:0] i_rad,
    input  wire                 [39:0] i_num,
    input  wire                 [33:0] i_den,
    output tcpm_pkg::t_rdiv_sts        o_sts,
    output logic                [31:0] o_res
);
    import tcpm_pkg::*;

    // Shared compare/subtract: square root takes two radicand bits a cycle,
    // division one quotient bit a cycle.
    logic [35:0] r_rem;
    logic [63:0] r_rad;
    logic [31:0] r_res;
    logic [33:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic        r_ovf;
    t_rdiv_mode  r_mode;

    logic [35:0] rem_sh;
    logic [35:0] lhs;
    logic [35:0] rhs;
    logic [35:0] diff;
    logic [35:0] kept;
    logic        take;
    logic        last;

    always_comb begin
        rem_sh = {r_rem[33:0], r_rad[63:62]};
        if (r_mode == RD_SQRT) begin
            lhs = rem_sh;
            rhs = {2'b00, r_res, 2'b01};
        end else begin
            lhs = r_rem;
            rhs = {2'b00, r_den};
        end
        take = (lhs >= rhs);
        diff = lhs - rhs;
        kept = take ? diff : lhs;
        last = (r_mode == RD_SQRT) ? (r_cnt == 5'd31) : (r_cnt == 5'd30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mode <= RD_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mode <= i_ctl.mode;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_res <= '0;
            r_rad <= i_rad;
            r_den <= i_den;
            if (i_ctl.mode == RD_SQRT) begin
                r_rem <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_rem <= i_num[35:0];
                r_ovf <= ({1'b0, i_num} >= {6'b0, i_den, 1'b0});
            end
        end else if (r_busy) begin
            r_res <= {r_res[30:0], take};
            if (r_mode == RD_SQRT) begin
                r_rem <= kept;
                r_rad <= {r_rad[61:0], 2'b00};
            end else begin
                r_rem <= {kept[34:0], 1'b0};
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.ovf  = r_ovf;
    assign o_res      = r_res;
endmodule
`default_nettype wire

FILE: sim/tb_teleop_clutch_pose_mapper_unit.sv
`timescale 1ns / 1ps
module tb_teleop_clutch_pose_mapper_unit;
    import tcpm_pkg::*;

    // Watchdog limit on idle cycles with no handshake of any kind.
    localparam int WATCHDOG_LIMIT = 20000;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    t_in    in_data = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    t_out   out_data;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic [3:0] cfg_data = '0;

    always #5 clk = ~clk;

    teleop_clutch_pose_mapper_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    // Mirror of the block's state.
    logic [3:0]         m_scale;
    logic signed [31:0] m_last_hq [4];
    logic signed [31:0] m_cmd_pos [3];
    logic signed [31:0] m_cmd_q   [4];
    logic signed [31:0] m_hold_pos[3];
    logic signed [31:0] m_hold_q  [4];
    logic signed [31:0] m_off_pos [3];
    logic signed [31:0] m_off_q   [4];
    logic               m_latched;
    logic               m_seeded;

    t_out pose_queue[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   bursts_on = 1'b1;
    bit   hold_off_req = 1'b0;

    function automatic logic signed [63:0] asr(input logic signed [63:0] v, input int n);
        return v >>> n;
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] dbl(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return asr(64'(a) * 64'(b), 29);
    endfunction

    function automatic logic signed [63:0] pp(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        return asr(64'(a) * 64'(b), 2);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // num * 2^30 / den, truncated toward zero, saturated
    function automatic logic signed [31:0] frac_div(input logic signed [63:0] num,
                                                    input logic signed [63:0] den);
        logic [63:0] m, d, hi, rem, mag;
        m = num < 0 ? -num : num;
        d = den;
        hi = m / d;
        rem = m % d;
        if (hi >= 2) mag = 64'd1 << 32;
        else mag = (hi << 30) + ((rem << 30) / d);
        return clip32(num < 0 ? -$signed(mag) : $signed(mag));
    endfunction

    task automatic quat_mult(input logic signed [31:0] a[4], input logic signed [31:0] b[4],
                             output logic signed [31:0] o[4]);
        logic signed [63:0] w, x, y, z;
        w = pp(a[0], b[0]) - pp(a[1], b[1]) - pp(a[2], b[2]) - pp(a[3], b[3]);
        x = pp(a[0], b[1]) + pp(a[1], b[0]) + pp(a[2], b[3]) - pp(a[3], b[2]);
        y = pp(a[0], b[2]) - pp(a[1], b[3]) + pp(a[2], b[0]) + pp(a[3], b[1]);
        z = pp(a[0], b[3]) + pp(a[1], b[2]) - pp(a[2], b[1]) + pp(a[3], b[0]);
        o[0] = clip32(asr(w, 28));
        o[1] = clip32(asr(x, 28));
        o[2] = clip32(asr(y, 28));
        o[3] = clip32(asr(z, 28));
    endtask

    // Haptic orientation into the robot frame: R * turn, then trace formula.
    task automatic robot_orient(input logic signed [31:0] q[4], output logic signed [31:0] e[4]);
        logic signed [63:0] r[3][3], t[3][3], tr, ew;
        logic signed [63:0] one;
        one = 64'sd1 << 30;
        r[0][0] = one - dbl(q[2], q[2]) - dbl(q[3], q[3]);
        r[0][1] = dbl(q[1], q[2]) - dbl(q[0], q[3]);
        r[0][2] = dbl(q[1], q[3]) + dbl(q[0], q[2]);
        r[1][0] = dbl(q[1], q[2]) + dbl(q[0], q[3]);
        r[1][1] = one - dbl(q[1], q[1]) - dbl(q[3], q[3]);
        r[1][2] = dbl(q[2], q[3]) - dbl(q[0], q[1]);
        r[2][0] = dbl(q[1], q[3]) - dbl(q[0], q[2]);
        r[2][1] = dbl(q[2], q[3]) + dbl(q[0], q[1]);
        r[2][2] = one - dbl(q[1], q[1]) - dbl(q[2], q[2]);
        // turn = {0,0,-1; 0,1,0; 1,0,0}: col0 = r[.][2], col1 = r[.][1], col2 = -r[.][0]
        for (int i = 0; i < 3; i++) begin
            t[i][0] = r[i][2];
            t[i][1] = r[i][1];
            t[i][2] = -r[i][0];
        end
        tr = one + t[0][0] + t[1][1] + t[2][2];
        if (tr < 0) tr = 0;
        if (tr > (64'sd1 << 34) - 1) tr = (64'sd1 << 34) - 1;
        ew = $signed(root64(64'(tr) << 30) >> 1);
        e[0] = ew[31:0];
        if (ew == 0) begin
            // zero trace root: vector part forced to zero
            e[1] = 0; e[2] = 0; e[3] = 0;
        end else begin
            e[1] = frac_div(t[2][1] - t[1][2], 4 * ew);
            e[2] = frac_div(t[0][2] - t[2][0], 4 * ew);
            e[3] = frac_div(t[1][0] - t[0][1], 4 * ew);
        end
    endtask

    task automatic mirror_reset();
        m_scale = SCALE_RESET;
        m_last_hq = '{Q30_ONE, 0, 0, 0};
        m_cmd_q   = '{Q30_ONE, 0, 0, 0};
        m_hold_q  = '{Q30_ONE, 0, 0, 0};
        m_off_q   = '{Q30_ONE, 0, 0, 0};
        m_cmd_pos = '{0, 0, 0};
        m_hold_pos = '{0, 0, 0};
        m_off_pos = '{0, 0, 0};
        m_latched = 1'b0;
        m_seeded = 1'b0;
    endtask

    // Advance the mirror by one accepted request; queue the pose it commands.
    task automatic predict_pose(input t_in it);
        logic signed [31:0] p[3], q[4], e[4], cq[4];
        logic signed [63:0] sc[3];
        t_out r;
        p = '{it.pos_x, it.pos_y, it.pos_z};
        if (it.opcode == OP_SEED) begin
            if (!m_seeded) begin
                m_hold_pos = p;
                m_hold_q = m_last_hq;
                m_seeded = 1'b1;
            end
            return;
        end
        q = '{it.quat_w, it.quat_x, it.quat_y, it.quat_z};
        m_last_hq = q;
        robot_orient(q, e);
        for (int i = 0; i < 3; i++) sc[i] = 64'(p[i]) * $signed({60'd0, m_scale});
        if (it.clutch_engaged) begin
            for (int i = 0; i < 3; i++) m_cmd_pos[i] = clip32(sc[i] - m_off_pos[i]);
            quat_mult(m_off_q, e, m_cmd_q);
            m_latched = 1'b0;
            r = '{m_cmd_pos[0], m_cmd_pos[1], m_cmd_pos[2],
                  m_cmd_q[0], m_cmd_q[1], m_cmd_q[2], m_cmd_q[3], 1'b0};
        end else begin
            if (!m_latched) begin
                m_hold_pos = m_cmd_pos;
                m_hold_q = m_cmd_q;
                m_latched = 1'b1;
            end
            r = '{m_hold_pos[0], m_hold_pos[1], m_hold_pos[2],
                  m_hold_q[0], m_hold_q[1], m_hold_q[2], m_hold_q[3], 1'b1};
            for (int i = 0; i < 3; i++) m_off_pos[i] = clip32(sc[i] - m_hold_pos[i]);
            cq = '{e[0], negsat(e[1]), negsat(e[2]), negsat(e[3])};
            quat_mult(m_hold_q, cq, m_off_q);
        end
        pose_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Sink: random stall bursts, plus a long hold-off on request.
    initial begin : sink
        int n;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                n = 0;
                while (n < 5000) begin
                    @(posedge clk);
                    n++;
                end
                hold_off_req = 1'b0;
                out_stall <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pose_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = pose_queue.pop_front();
                if (out_data.target_x !== want.target_x)
                    report_mismatch("target_x", out_data.target_x, want.target_x);
                if (out_data.target_y !== want.target_y)
                    report_mismatch("target_y", out_data.target_y, want.target_y);
                if (out_data.target_z !== want.target_z)
                    report_mismatch("target_z", out_data.target_z, want.target_z);
                if (out_data.target_qw !== want.target_qw)
                    report_mismatch("target_qw", out_data.target_qw, want.target_qw);
                if (out_data.target_qx !== want.target_qx)
                    report_mismatch("target_qx", out_data.target_qx, want.target_qx);
                if (out_data.target_qy !== want.target_qy)
                    report_mismatch("target_qy", out_data.target_qy, want.target_qy);
                if (out_data.target_qz !== want.target_qz)
                    report_mismatch("target_qz", out_data.target_qz, want.target_qz);
                if (out_data.holding !== want.holding)
                    report_mismatch("holding", out_data.holding, want.holding);
            end
        end
    end

    // Watchdog: cycles with no handshake of any kind.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one request; valid stays high back to back unless a gap is drawn.
    task automatic send_request(input t_in it);
        if (bursts_on && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pose(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge clk);
        // extra idle time; a trailing seed already took effect on acceptance
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_scale(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        m_scale = v;
    endtask

    function automatic logic signed [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed($urandom_range(0, 32'h7FFF)) - 32'sh4000;
            default: return $signed($urandom());
        endcase
    endfunction

    // Unit-ish quaternion components near Q2.30 one, or raw noise.
    function automatic t_in rnd_tick(input logic clutch);
        t_in it;
        it.opcode = OP_TICK;
        it.pos_x = rnd_word();
        it.pos_y = rnd_word();
        it.pos_z = rnd_word();
        if ($urandom_range(0, 3) != 0) begin
            it.quat_w = $signed($urandom_range(0, 32'h8000_0000)) - Q30_ONE;
            it.quat_x = $signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000;
            it.quat_y = $signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000;
            it.quat_z = $signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000;
        end else begin
            it.quat_w = rnd_word();
            it.quat_x = rnd_word();
            it.quat_y = rnd_word();
            it.quat_z = rnd_word();
        end
        it.clutch_engaged = clutch;
        return it;
    endfunction

    function automatic t_in mk(input logic op, input logic signed [31:0] p,
                               input logic signed [31:0] w, input logic signed [31:0] v,
                               input logic c);
        return '{op, p, -p, p, w, v, -v, v, c};
    endfunction

    task automatic test_directed();
        // seed before any tick, then a repeated seed that must be ignored
        send_request(mk(OP_SEED, 32'sh0100_0000, 0, 0, 1'b0));
        send_request(mk(OP_SEED, 32'sh0200_0000, 0, 0, 1'b1));
        // released first tick overwrites the seeded hold pose
        send_request(mk(OP_TICK, 32'sh0080_0000, Q30_ONE, 0, 1'b0));
        send_request(mk(OP_TICK, 32'sh0080_0000, Q30_ONE, 0, 1'b1));
        send_request(mk(OP_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
        send_request(mk(OP_TICK, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1));
        send_request(mk(OP_TICK, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0));
        send_request(mk(OP_TICK, -32'sd1, -32'sd1, 32'sh7FFF_FFFF, 1'b0));
        // zero quaternion, a 180-degree turn about the frame axis, then a zero trace root
        send_request(mk(OP_TICK, 0, 0, 0, 1'b0));
        send_request('{OP_TICK, 0, 0, 0, 0, 0, Q30_ONE, 0, 1'b1});
        send_request('{OP_TICK, 1, 2, 3, Q30_ONE, 32'sh8000_0000, 0, 0, 1'b0});
        send_request(mk(OP_TICK, 32'sh0123_4567, 32'sh2000_0000, 32'sh1000_0000, 1'b1));
        drain();
    endtask

    task automatic test_scales();
        logic [3:0] s[5] = '{4'd0, 4'd15, 4'd1, 4'd7, 4'd3};
        foreach (s[k]) begin
            write_scale(s[k]);
            for (int i = 0; i < 6; i++) send_request(rnd_tick(i % 3 != 2));
            drain();
        end
    endtask

    task automatic test_receiver_hold_off();
        hold_off_req = 1'b1;
        for (int i = 0; i < 5; i++) send_request(rnd_tick(1'b1));
        drain();
    endtask

    task automatic test_random(input int count, input bit idle_on);
        t_in it;
        logic clutch;
        bursts_on = idle_on;
        clutch = 1'b1;
        for (int i = 0; i < count; i++) begin
            // clutch runs: several engaged ticks, then several released
            if ($urandom_range(0, 4) == 0) clutch = ~clutch;
            if ($urandom_range(0, 19) == 0) begin
                it = rnd_tick(clutch);
                it.opcode = OP_SEED;
                it.clutch_engaged = $urandom_range(0, 1);
            end else begin
                it = rnd_tick(clutch);
            end
            send_request(it);
            if (i % 150 == 149) begin
                drain();
                write_scale($urandom_range(0, 15));
            end
        end
        drain();
    endtask

    initial begin
        mirror_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_scales();
        test_receiver_hold_off();
        test_random(480, 1'b1);
        test_random(60, 1'b0);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: teleop_clutch_pose_mapper_unit.f
hdl/tcpm_pkg.sv
hdl/tcpm_mul.sv
hdl/tcpm_rdiv.sv
hdl/teleop_clutch_pose_mapper_unit.sv
sim/tb_teleop_clutch_pose_mapper_unit.sv
